>>> rtl/sensor_frame_checksum_parser_assert.svh
// ----------------------------------------------------------------------------
// Sensor frame checksum parser assertion macros
// Clocked, reset-gated assertion shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_ASSERT_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SFCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SFCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared constants and types of the sensor frame checksum parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcp_pkg;

	localparam int unsigned FrameLength = 9;
	localparam int unsigned CheckPos    = 8;
	localparam int unsigned PosW        = 4;

	localparam logic [7:0] MarkerReset = 8'hFF;

	typedef enum logic {
		CMD_BYTE  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	// one result transaction
	typedef struct packed {
		logic        frame_done;
		logic        frame_good;
		logic [15:0] concentration_tenths;
		logic [15:0] error_total;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/sfcp_parser.sv
// ----------------------------------------------------------------------------
// sfcp_parser
// Frame state, checksum and counters; computes one result per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             cmd,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [7:0]       start_marker,
	output sfcp_pkg::result_t     result
);

	localparam logic [sfcp_pkg::PosW-1:0] LastPos = sfcp_pkg::PosW'(sfcp_pkg::CheckPos);

	logic                      in_frame_q, in_frame_d;
	logic [sfcp_pkg::PosW-1:0] pos_q, pos_d;
	logic [7:0]                sum_q, sum_d;
	logic [7:0]                vhigh_q, vhigh_d;
	logic [7:0]                vlow_q, vlow_d;
	logic [15:0]               last_q, last_d;
	logic [15:0]               fail_q, fail_d;

	logic                      open_frame;
	logic                      active;
	logic [sfcp_pkg::PosW-1:0] pos_cur;
	logic [7:0]                sum_cur;
	logic [7:0]                sum_new;
	logic                      done;
	logic                      good;

	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		sum_d      = sum_q;
		vhigh_d    = vhigh_q;
		vlow_d     = vlow_q;
		last_d     = last_q;
		fail_d     = fail_q;
		done       = 1'b0;
		good       = 1'b0;
		open_frame = !in_frame_q && (rx_byte == start_marker);
		active     = in_frame_q || open_frame;
		pos_cur    = open_frame ? '0 : pos_q;
		sum_cur    = open_frame ? '0 : sum_q;
		sum_new    = sum_cur;

		if (cmd == sfcp_pkg::CMD_CLEAR) begin
			in_frame_d = 1'b0;
			pos_d      = '0;
			sum_d      = '0;
			vhigh_d    = '0;
			vlow_d     = '0;
		end else if (active) begin
			if (pos_cur inside {[4'd1:4'd7]}) begin
				sum_new = 8'(sum_cur + rx_byte);
			end
			if (pos_cur == 4'd2) begin
				vhigh_d = rx_byte;
			end
			if (pos_cur == 4'd3) begin
				vlow_d = rx_byte;
			end
			if (pos_cur == LastPos) begin
				// checksum byte: must cancel bytes 1..7
				done = 1'b1;
				good = (rx_byte == 8'(8'd0 - sum_new));
				if (good) begin
					last_d = {vhigh_q, vlow_q};
				end else if (fail_q != 16'hFFFF) begin
					fail_d = 16'(fail_q + 16'd1);
				end
				in_frame_d = 1'b0;
				pos_d      = '0;
				sum_d      = '0;
				vhigh_d    = '0;
				vlow_d     = '0;
			end else begin
				in_frame_d = 1'b1;
				pos_d      = sfcp_pkg::PosW'(pos_cur + 4'd1);
				sum_d      = sum_new;
			end
		end
	end

	always_comb begin
		result.frame_done           = done;
		result.frame_good           = good;
		result.concentration_tenths = last_d;
		result.error_total          = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			sum_q      <= '0;
			vhigh_q    <= '0;
			vlow_q     <= '0;
			last_q     <= '0;
			fail_q     <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			sum_q      <= sum_d;
			vhigh_q    <= vhigh_d;
			vlow_q     <= vlow_d;
			last_q     <= last_d;
			fail_q     <= fail_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sfcp_out_reg.sv
// ----------------------------------------------------------------------------
// sfcp_out_reg
// One-entry result register between the parser and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire sfcp_pkg::result_t result_in,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output sfcp_pkg::result_t      result_out,
	output logic                   in_ready
);

	logic              valid_s1;
	sfcp_pkg::result_t data_s1;

	// free, or emptying this cycle
	assign in_ready   = !valid_s1 || out_ready;
	assign out_valid  = valid_s1;
	assign result_out = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= result_in;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sensor_frame_checksum_parser.sv
// ----------------------------------------------------------------------------
// sensor_frame_checksum_parser
// Parses nine-byte serial sensor frames, checks the checksum and reports the
// last good concentration and a saturating checksum failure count.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tuser: cmd; tdata: rx_byte
// m_*      out  m_tvalid/m_tready    tuser: frame_done, frame_good;
//                                    tdata: concentration_tenths, error_total
// cfg_*    in   cfg_valid/cfg_ready  cfg_data: start_marker (always ready)
//
// Cycles: one input transaction per clock while s_tready is high; its result
// transaction is shown from the output register in the cycle after it is accepted.
// Reset: arst_n clears frame state, counters, output valid, and sets the
// start marker to 0xFF.
// Stalls: s_tready drops only while a result waits and m_tready is low; a
// result taken in the same cycle frees the register for the next input.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_checksum_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] cmd (0 byte, 1 clear frame)
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] concentration_tenths, [31:16] error_total
	output logic [1:0]       m_tuser,   // [0] frame_done, [1] frame_good
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data   // [7:0] start_marker
);

	logic [7:0]        marker_q;
	logic              step;
	sfcp_pkg::result_t res_d;
	sfcp_pkg::result_t res_q;

	// configuration must be written only while idle (the block does not enforce it); always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= sfcp_pkg::MarkerReset;
		end else if (cfg_valid) begin
			marker_q <= cfg_data;
		end
	end

	// an input transaction advances the parser and loads the output register
	assign step = s_tvalid && s_tready;

	sfcp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.cmd          (s_tuser),
		.rx_byte      (s_tdata),
		.start_marker (marker_q),
		.result       (res_d)
	);

	sfcp_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (step),
		.result_in  (res_d),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.result_out (res_q),
		.in_ready   (s_tready)
	);

	assign m_tdata = {res_q.error_total, res_q.concentration_tenths};
	assign m_tuser = {res_q.frame_good, res_q.frame_done};

endmodule

`default_nettype wire

>>> rtl/sfcp_checker.sv
// ----------------------------------------------------------------------------
// sfcp_checker
// Port-level checks of the sensor frame checksum parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_frame_checksum_parser_assert.svh"

module sfcp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// a good frame is always a completed frame
	`SFCP_ASSERT_NOW(a_good_done, m_tvalid, !(m_tuser[1] && !m_tuser[0]), "frame_good without frame_done")

	// the output register never blocks input while empty
	`SFCP_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "s_tready low with empty output")

	// every input transaction shows its result next cycle
	`SFCP_ASSERT_NEXT(a_in_to_out, s_tvalid && s_tready, m_tvalid, "result missing after input")

	// a clear command never completes a frame
	`SFCP_ASSERT_NEXT(a_clear_no_done, s_tvalid && s_tready && s_tuser, !m_tuser[0], "frame_done on clear")

	// stalled result holds
	`SFCP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind sensor_frame_checksum_parser sfcp_checker u_sfcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/tb_sensor_frame_checksum_parser.sv
// ----------------------------------------------------------------------------
// tb_sensor_frame_checksum_parser
// Self-checking bench for the nine-byte sensor frame parser. A local model of
// the parser predicts one result transaction per accepted input transaction;
// a monitor compares every output transaction field by field, in order.
// Stimulus covers directed corner cases, several start markers, random runs
// of frames, noise and aborts, and failure counting under stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_frame_checksum_parser;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 6;
	localparam int TIMEOUT_CYCLES = 50_000;
	localparam int RANDOM_ITEMS   = 680;

	// ------------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tuser   = sfcp_pkg::CMD_BYTE;
	logic        m_tvalid;
	logic        m_tready  = 1'b1;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = 8'h00;

	always #(CLK_PERIOD / 2) clk = ~clk;

	sensor_frame_checksum_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] rx_byte
		.s_tuser  (s_tuser),   // [0] cmd
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [15:0] concentration_tenths, [31:16] error_total
		.m_tuser  (m_tuser),   // [0] frame_done, [1] frame_good
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)   // [7:0] start_marker
	);

	// ------------------------------------------------------------------------
	// parser model: mirrors the block state, updated once per accepted input
	// ------------------------------------------------------------------------
	logic [7:0]  marker_cfg  = sfcp_pkg::MarkerReset;
	logic        frame_open  = 1'b0;
	logic [3:0]  frame_pos   = '0;
	logic [7:0]  frame_sum   = '0;
	logic [7:0]  conc_high   = '0;
	logic [7:0]  conc_low    = '0;
	logic [15:0] held_conc   = '0;
	logic [15:0] fail_total  = '0;

	sfcp_pkg::result_t pending_results[$];
	int                mismatch_count = 0;
	int                item_total     = 0;

	function automatic void drop_partial_frame();
		frame_open = 1'b0;
		frame_pos  = '0;
		frame_sum  = '0;
		conc_high  = '0;
		conc_low   = '0;
	endfunction

	function automatic sfcp_pkg::result_t parse_byte(sfcp_pkg::cmd_t c, logic [7:0] b);
		sfcp_pkg::result_t r;
		logic [3:0]        pos;
		r = '0;
		if (c == sfcp_pkg::CMD_CLEAR) begin
			drop_partial_frame();
		end else begin
			// a marker only opens a frame from idle; inside a frame it is data
			if (!frame_open && b == marker_cfg) begin
				frame_open = 1'b1;
				frame_pos  = '0;
				frame_sum  = '0;
			end
			if (frame_open) begin
				pos = frame_pos;
				if (pos >= 1 && pos < sfcp_pkg::CheckPos)
					frame_sum = frame_sum + b;
				if (pos == 2)
					conc_high = b;
				if (pos == 3)
					conc_low = b;
				pos = 4'(pos + 4'd1);
				if (pos >= sfcp_pkg::FrameLength) begin
					r.frame_done = 1'b1;
					if (b == 8'(8'h00 - frame_sum)) begin
						r.frame_good = 1'b1;
						held_conc    = {conc_high, conc_low};
					end else if (fail_total != 16'hFFFF) begin
						fail_total = 16'(fail_total + 16'd1);
					end
					drop_partial_frame();
				end else begin
					frame_pos = pos;
				end
			end
		end
		r.concentration_tenths = held_conc;
		r.error_total          = fail_total;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// traffic shaping
	// ------------------------------------------------------------------------
	bit         tx_gaps_on  = 1'b0;
	bit         rx_stall_on = 1'b0;
	int         burst_left  = 0;
	logic [3:0] stall_phase = '0;
	logic [15:0] stall_mask = 16'hFFFF;

	// receiver: a random 16-bit ready mask, replayed bit by bit and refreshed when the 4-bit phase wraps
	always @(posedge clk) begin
		stall_phase <= 4'(stall_phase + 4'd1);
		if (stall_phase == 4'd15)
			stall_mask <= 16'($urandom);
		m_tready <= !rx_stall_on || stall_mask[stall_phase];
	end

	// one input transaction; predicts its result at the accepting edge
	task automatic send_item(sfcp_pkg::cmd_t c, logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(parse_byte(c, b));
		item_total++;
		if (tx_gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap        = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// full frame from the current marker; corrupt flips checksum bits
	task automatic send_frame(logic [7:0] hi, logic [7:0] lo, bit corrupt);
		logic [7:0] body[1:7];
		logic [7:0] sum;
		logic [7:0] chk;
		sum = '0;
		for (int i = 1; i <= 7; i++) begin
			body[i] = (i == 2) ? hi : (i == 3) ? lo : 8'($urandom);
			sum     = sum + body[i];
		end
		chk = 8'h00 - sum;
		if (corrupt)
			chk = chk ^ 8'($urandom_range(1, 255));
		send_item(sfcp_pkg::CMD_BYTE, marker_cfg);
		for (int i = 1; i <= 7; i++)
			send_item(sfcp_pkg::CMD_BYTE, body[i]);
		send_item(sfcp_pkg::CMD_BYTE, chk);
	endtask

	// stop sending and let every expected result come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_marker(logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		marker_cfg = v;
	endtask

	// ------------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string field, int unsigned want, int unsigned got);
		mismatch_count++;
		$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
	endtask

	always @(posedge clk) begin : result_check
		sfcp_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$error("result transaction with no expectation pending");
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[0] !== want.frame_done)
					report_mismatch("frame_done", 32'(want.frame_done), 32'(m_tuser[0]));
				if (m_tuser[1] !== want.frame_good)
					report_mismatch("frame_good", 32'(want.frame_good), 32'(m_tuser[1]));
				if (m_tdata[15:0] !== want.concentration_tenths)
					report_mismatch("concentration_tenths",
						32'(want.concentration_tenths), 32'(m_tdata[15:0]));
				if (m_tdata[31:16] !== want.error_total)
					report_mismatch("error_total", 32'(want.error_total),
						32'(m_tdata[31:16]));
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset marker: idle bytes, clears, marker as data, good/bad, abort
	task automatic test_directed();
		send_item(sfcp_pkg::CMD_BYTE, 8'h00);          // idle, not a marker: ignored
		send_item(sfcp_pkg::CMD_CLEAR, 8'hFF);         // clear while idle, byte ignored
		send_frame(8'hFF, 8'hFF, 1'b1);                // bad; marker value inside as data
		send_frame(8'hFF, 8'hFF, 1'b0);                // good, largest concentration
		send_item(sfcp_pkg::CMD_BYTE, marker_cfg);     // aborted frame
		send_item(sfcp_pkg::CMD_BYTE, 8'h12);
		send_item(sfcp_pkg::CMD_BYTE, 8'h34);
		send_item(sfcp_pkg::CMD_CLEAR, 8'h00);
		wait_idle();
	endtask

	// several markers, the extremes among them
	task automatic test_marker_settings();
		logic [7:0] markers[4];
		markers = '{8'h00, 8'h5A, 8'($urandom), 8'hFF};
		foreach (markers[k]) begin
			write_marker(markers[k]);
			send_item(sfcp_pkg::CMD_BYTE, markers[k] ^ 8'h81);
			send_frame(8'h00, 8'h00, 1'b0);
			send_frame(8'($urandom), 8'($urandom), 1'b0);
			send_frame(8'($urandom), 8'($urandom), 1'b1);
			wait_idle();
		end
	endtask

	// mostly well-formed frames, plus aborts, noise and stray clears
	task automatic test_random();
		logic [7:0] markers[4];
		int         start;
		int         pick;
		int         k;
		markers = '{8'($urandom), 8'h00, 8'hFF, 8'($urandom)};
		foreach (markers[p]) begin
			write_marker(markers[p]);
			start = item_total;
			while (item_total - start < RANDOM_ITEMS / 4) begin
				// reshuffle idling at random, on about one pick in four
				if ($urandom_range(0, 3) == 0) begin
					tx_gaps_on  = $urandom_range(0, 2) != 0;
					rx_stall_on = $urandom_range(0, 2) != 0;
				end
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_frame(8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
				end else if (pick < 80) begin
					k = $urandom_range(1, 8);
					send_item(sfcp_pkg::CMD_BYTE, marker_cfg);
					repeat (k - 1) send_item(sfcp_pkg::CMD_BYTE, 8'($urandom));
					send_item(sfcp_pkg::CMD_CLEAR, 8'($urandom));
				end else if (pick < 92) begin
					repeat ($urandom_range(1, 5)) send_item(sfcp_pkg::CMD_BYTE, 8'($urandom));
					if ($urandom_range(0, 1))
						send_item(sfcp_pkg::CMD_CLEAR, 8'($urandom));
				end else begin
					send_item(sfcp_pkg::CMD_CLEAR, 8'($urandom));
				end
			end
			wait_idle();
		end
		tx_gaps_on  = 1'b0;
		rx_stall_on = 1'b0;
	endtask

	// failure counting and concentration hold across bad frames, under stalls
	task automatic test_counter_failures();
		write_marker(sfcp_pkg::MarkerReset);
		tx_gaps_on  = 1'b1;
		rx_stall_on = 1'b1;
		repeat (3) send_frame(8'($urandom), 8'($urandom), 1'b1);
		send_frame(8'($urandom), 8'($urandom), 1'b0);
		send_frame(8'($urandom), 8'($urandom), 1'b1);
		send_frame(8'($urandom), 8'($urandom), 1'b0);
		wait_idle();
		tx_gaps_on  = 1'b0;
		rx_stall_on = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_marker_settings();
		test_random();
		test_counter_failures();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$error("%0d expected result transactions never arrived",
				pending_results.size());
		end
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$error("timeout");
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
